// ----- src/lts_pkg.sv -----
package lts_pkg;

  localparam int ID_W     = 15;
  localparam int TIX_W    = 16;
  localparam int RND_W    = 32;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 20;
  localparam int COUNT_W  = 5;

  typedef logic [ID_W-1:0]     id_t;
  typedef logic [TIX_W-1:0]    tix_t;
  typedef logic [RND_W-1:0]    rnd_t;
  typedef logic [TOTAL_W-1:0]  total_out_t;
  typedef logic [COUNT_W-1:0]  count_out_t;

  typedef enum logic [1:0] {
    ACT_ENQ  = 2'd0,
    ACT_DEQ  = 2'd1,
    ACT_PICK = 2'd2,
    ACT_CHG  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_ABSENT    = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SHIFT,
    S_DIV,
    S_WALK,
    S_FINISH
  } state_t;

  typedef struct packed {
    id_t  id;
    tix_t tickets;
  } entry_t;

endpackage

// ----- src/lts_req_if.sv -----
interface lts_req_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  lts_pkg::id_t         task_id;
  lts_pkg::tix_t        tickets;
  lts_pkg::rnd_t        random_value;

  modport source (output valid, action, task_id, tickets, random_value, input ready);
  modport sink   (input valid, action, task_id, tickets, random_value, output ready);
endinterface

// ----- src/lts_rsp_if.sv -----
interface lts_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 status;
  logic                       winner_valid;
  lts_pkg::id_t               winner_id;
  lts_pkg::total_out_t        lucky_number;
  lts_pkg::total_out_t        ticket_total;
  lts_pkg::count_out_t        entry_count;

  modport source (output valid, status, winner_valid, winner_id, lucky_number,
                  ticket_total, entry_count, input ready);
  modport sink   (input valid, status, winner_valid, winner_id, lucky_number,
                  ticket_total, entry_count, output ready);
endinterface

// ----- src/lts_divmod.sv -----
// Restoring remainder unit: one dividend bit per cycle.
module lts_divmod #(
  parameter int DIV_W = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  lts_pkg::rnd_t        dividend,
  input  logic [DIV_W-1:0]     divisor,
  output logic                 done,
  output logic [DIV_W-1:0]     remainder
);

  localparam int STEP_W = $clog2(lts_pkg::RND_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  lts_pkg::rnd_t     dq;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W:0]    shifted;

  assign shifted   = {rem, dq[lts_pkg::RND_W-1]};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(lts_pkg::RND_W - 1);
        dq   <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        // rem stays below the divisor, so DIV_W bits hold it
        if (shifted >= {1'b0, dvs}) begin
          rem <= DIV_W'(shifted - {1'b0, dvs});
        end else begin
          rem <= shifted[DIV_W-1:0];
        end
        dq   <= {dq[lts_pkg::RND_W-2:0], 1'b0};
        step <= step - STEP_W'(1);
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/lottery_task_scheduler.sv -----
// Channel  Dir  Modport  Payload
// req      in   sink     action, task_id, tickets, random_value
// rsp      out  source   status, winner_valid, winner_id, lucky_number,
//                        ticket_total, entry_count
//
// One item at a time; the task table sits in a one-port-read, one-port-write
// RAM, scanned one entry per cycle. Enqueue/change: a search of the queued
// tasks. Dequeue: search plus compaction sweep. Pick: a pass through the
// remainder unit, then the walk.
// Reset (rst, synchronous) empties the table at once; no clearing pass.
// A held result waits in the output register while the next item is taken.
module lottery_task_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input logic       clk,
  input logic       rst,
  lts_req_if.sink   req,
  lts_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int TOT_W = $clog2(MAX_TASKS * 65535 + 1);

  lts_pkg::state_t  state, state_next;
  lts_pkg::action_t act, act_next;
  lts_pkg::id_t     id_q, id_q_next;
  lts_pkg::tix_t    tix_q, tix_q_next;
  logic [CNT_W-1:0] count, count_next;
  logic [TOT_W-1:0] total, total_next;
  logic [CNT_W-1:0] scan_idx, scan_idx_next;
  logic             pend, pend_next;
  logic [IDX_W-1:0] pend_idx, pend_idx_next;
  logic [TOT_W-1:0] run, run_next;
  logic [TOT_W-1:0] draw, draw_next;

  lts_pkg::status_t    res_status, res_status_next;
  logic                res_wvalid, res_wvalid_next;
  lts_pkg::id_t        res_wid, res_wid_next;
  lts_pkg::total_out_t res_lucky, res_lucky_next;

  logic                o_valid, o_valid_next;
  lts_pkg::status_t    o_status, o_status_next;
  logic                o_wvalid, o_wvalid_next;
  lts_pkg::id_t        o_wid, o_wid_next;
  lts_pkg::total_out_t o_lucky, o_lucky_next;
  lts_pkg::total_out_t o_total, o_total_next;
  lts_pkg::count_out_t o_count, o_count_next;

  // task table
  lts_pkg::entry_t  mem [MAX_TASKS];
  lts_pkg::entry_t  rdata;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  lts_pkg::entry_t  mem_wdata;

  logic             div_start, div_done;
  logic [TOT_W-1:0] div_rem;

  logic             hit, scan_end;
  logic [TOT_W-1:0] run_sum;

  lts_divmod #(.DIV_W(TOT_W)) u_divmod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (req.random_value),
    .divisor   (total),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  assign req.ready        = (state == lts_pkg::S_IDLE);
  assign rsp.valid        = o_valid;
  assign rsp.status       = o_status;
  assign rsp.winner_valid = o_wvalid;
  assign rsp.winner_id    = o_wid;
  assign rsp.lucky_number = o_lucky;
  assign rsp.ticket_total = o_total;
  assign rsp.entry_count  = o_count;

  assign hit      = pend && (rdata.id == id_q);
  assign scan_end = !pend && (scan_idx == count);
  assign run_sum  = run + TOT_W'(rdata.tickets);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lts_pkg::S_IDLE;
      count   <= '0;
      total   <= '0;
      pend    <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      total   <= total_next;
      pend    <= pend_next;
      o_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    act        <= act_next;
    id_q       <= id_q_next;
    tix_q      <= tix_q_next;
    scan_idx   <= scan_idx_next;
    pend_idx   <= pend_idx_next;
    run        <= run_next;
    draw       <= draw_next;
    res_status <= res_status_next;
    res_wvalid <= res_wvalid_next;
    res_wid    <= res_wid_next;
    res_lucky  <= res_lucky_next;
    o_status   <= o_status_next;
    o_wvalid   <= o_wvalid_next;
    o_wid      <= o_wid_next;
    o_lucky    <= o_lucky_next;
    o_total    <= o_total_next;
    o_count    <= o_count_next;
  end

  always_comb begin
    state_next      = state;
    act_next        = act;
    id_q_next       = id_q;
    tix_q_next      = tix_q;
    count_next      = count;
    total_next      = total;
    scan_idx_next   = scan_idx;
    pend_next       = 1'b0;
    pend_idx_next   = pend_idx;
    run_next        = run;
    draw_next       = draw;
    res_status_next = res_status;
    res_wvalid_next = res_wvalid;
    res_wid_next    = res_wid;
    res_lucky_next  = res_lucky;
    o_valid_next    = o_valid;
    o_status_next   = o_status;
    o_wvalid_next   = o_wvalid;
    o_wid_next      = o_wid;
    o_lucky_next    = o_lucky;
    o_total_next    = o_total;
    o_count_next    = o_count;
    mem_we          = 1'b0;
    mem_waddr       = pend_idx;
    mem_wdata       = rdata;
    mem_re          = 1'b0;
    mem_raddr       = scan_idx[IDX_W-1:0];
    div_start       = 1'b0;

    if (o_valid && rsp.ready) begin
      o_valid_next = 1'b0;
    end

    case (state)
      lts_pkg::S_IDLE: begin
        if (req.valid) begin
          act_next        = lts_pkg::action_t'(req.action);
          id_q_next       = req.task_id;
          tix_q_next      = req.tickets;
          res_status_next = lts_pkg::ST_OK;
          res_wvalid_next = 1'b0;
          res_wid_next    = '0;
          res_lucky_next  = '0;
          scan_idx_next   = '0;
          run_next        = '0;
          if (lts_pkg::action_t'(req.action) == lts_pkg::ACT_PICK) begin
            if (total == '0) begin
              res_status_next = lts_pkg::ST_EMPTY;
              state_next      = lts_pkg::S_FINISH;
            end else begin
              div_start  = 1'b1;
              state_next = lts_pkg::S_DIV;
            end
          end else begin
            state_next = lts_pkg::S_FIND;
          end
        end
      end

      lts_pkg::S_FIND: begin
        // one read issued per cycle, its data compared the cycle after
        if (scan_idx < count) begin
          mem_re        = 1'b1;
          scan_idx_next = scan_idx + CNT_W'(1);
          pend_next     = 1'b1;
          pend_idx_next = scan_idx[IDX_W-1:0];
        end
        if (hit) begin
          pend_next = 1'b0;
          case (act)
            lts_pkg::ACT_ENQ: begin
              res_status_next = lts_pkg::ST_DUPLICATE;
              state_next      = lts_pkg::S_FINISH;
            end
            lts_pkg::ACT_DEQ: begin
              total_next    = total - TOT_W'(rdata.tickets);
              scan_idx_next = CNT_W'(pend_idx) + CNT_W'(1);
              state_next    = lts_pkg::S_SHIFT;
            end
            lts_pkg::ACT_CHG: begin
              mem_we     = 1'b1;
              mem_waddr  = pend_idx;
              mem_wdata  = '{id: id_q, tickets: tix_q};
              total_next = total - TOT_W'(rdata.tickets) + TOT_W'(tix_q);
              state_next = lts_pkg::S_FINISH;
            end
            default: begin
              state_next = lts_pkg::S_FINISH;
            end
          endcase
        end else if (scan_end) begin
          if (act == lts_pkg::ACT_ENQ) begin
            if (count == CNT_W'(MAX_TASKS)) begin
              res_status_next = lts_pkg::ST_FULL;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = count[IDX_W-1:0];
              mem_wdata  = '{id: id_q, tickets: tix_q};
              count_next = count + CNT_W'(1);
              total_next = total + TOT_W'(tix_q);
            end
          end else begin
            res_status_next = lts_pkg::ST_ABSENT;
          end
          state_next = lts_pkg::S_FINISH;
        end
      end

      lts_pkg::S_SHIFT: begin
        // read entry j, write it back at j-1; the addresses never collide
        if (scan_idx < count) begin
          mem_re        = 1'b1;
          scan_idx_next = scan_idx + CNT_W'(1);
          pend_next     = 1'b1;
          pend_idx_next = scan_idx[IDX_W-1:0];
        end
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_idx - IDX_W'(1);
          mem_wdata = rdata;
        end
        if (scan_end) begin
          count_next = count - CNT_W'(1);
          state_next = lts_pkg::S_FINISH;
        end
      end

      lts_pkg::S_DIV: begin
        if (div_done) begin
          draw_next     = div_rem + TOT_W'(1);
          scan_idx_next = '0;
          run_next      = '0;
          state_next    = lts_pkg::S_WALK;
        end
      end

      lts_pkg::S_WALK: begin
        if (scan_idx < count) begin
          mem_re        = 1'b1;
          scan_idx_next = scan_idx + CNT_W'(1);
          pend_next     = 1'b1;
          pend_idx_next = scan_idx[IDX_W-1:0];
        end
        if (pend && (run_sum >= draw)) begin
          pend_next       = 1'b0;
          res_wvalid_next = 1'b1;
          res_wid_next    = rdata.id;
          res_lucky_next  = lts_pkg::total_out_t'(draw);
          state_next      = lts_pkg::S_FINISH;
        end else if (pend) begin
          run_next = run_sum;
        end else if (scan_end) begin
          res_status_next = lts_pkg::ST_EMPTY;
          state_next      = lts_pkg::S_FINISH;
        end
      end

      lts_pkg::S_FINISH: begin
        if (!o_valid || rsp.ready) begin
          o_valid_next  = 1'b1;
          o_status_next = res_status;
          o_wvalid_next = res_wvalid;
          o_wid_next    = res_wid;
          o_lucky_next  = res_lucky;
          o_total_next  = lts_pkg::total_out_t'(total);
          o_count_next  = lts_pkg::count_out_t'(count);
          state_next    = lts_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = lts_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lts_pkg::*;

  localparam int MAX_TASKS = 16;
  localparam int N_RANDOM  = 900;
  localparam int HOLD_AT   = 200;   // results seen before the long receiver hold-off
  localparam int HOLD_LEN  = 400;

  typedef struct packed {
    action_t act;
    id_t     id;
    tix_t    tix;
    rnd_t    rnd;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic       winner_valid;
    id_t        winner_id;
    total_out_t lucky;
    total_out_t total;
    count_out_t count;
  } result_t;

  typedef struct packed {
    action_t    act;
    id_t        id;
    tix_t       tix;
    rnd_t       rnd;
    logic [4:0] reps;     // id steps by one per repetition
    logic       typed;
    result_t    res;
  } dir_row_t;

  localparam int N_DIR = 17;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{ACT_PICK, 15'd0,     16'd0,     32'd0,          5'd1,  1'b1,
      '{ST_EMPTY,     1'b0, 15'd0,     20'd0, 20'd0,      5'd0}},
    '{ACT_DEQ,  15'd5,     16'd0,     32'd0,          5'd1,  1'b1,
      '{ST_ABSENT,    1'b0, 15'd0,     20'd0, 20'd0,      5'd0}},
    '{ACT_CHG,  15'd32767, 16'hFFFF,  32'd0,          5'd1,  1'b1,
      '{ST_ABSENT,    1'b0, 15'd0,     20'd0, 20'd0,      5'd0}},
    '{ACT_ENQ,  15'd0,     16'd0,     32'd0,          5'd1,  1'b1,
      '{ST_OK,        1'b0, 15'd0,     20'd0, 20'd0,      5'd1}},
    // only zero-ticket tasks queued: pool is still empty
    '{ACT_PICK, 15'd0,     16'd0,     32'hFFFFFFFF,   5'd1,  1'b1,
      '{ST_EMPTY,     1'b0, 15'd0,     20'd0, 20'd0,      5'd1}},
    '{ACT_ENQ,  15'd0,     16'd5,     32'd0,          5'd1,  1'b1,
      '{ST_DUPLICATE, 1'b0, 15'd0,     20'd0, 20'd0,      5'd1}},
    '{ACT_ENQ,  15'd32767, 16'hFFFF,  32'd0,          5'd1,  1'b1,
      '{ST_OK,        1'b0, 15'd0,     20'd0, 20'd65535,  5'd2}},
    '{ACT_PICK, 15'd0,     16'd0,     32'd0,          5'd1,  1'b1,
      '{ST_OK,        1'b1, 15'd32767, 20'd1, 20'd65535,  5'd2}},
    '{ACT_PICK, 15'd0,     16'd0,     32'hFFFFFFFF,   5'd1,  1'b1,
      '{ST_OK,        1'b1, 15'd32767, 20'd1, 20'd65535,  5'd2}},
    '{ACT_CHG,  15'd0,     16'hFFFF,  32'd0,          5'd1,  1'b1,
      '{ST_OK,        1'b0, 15'd0,     20'd0, 20'd131070, 5'd2}},
    '{ACT_ENQ,  15'd1,     16'hFFFF,  32'd0,          5'd14, 1'b0, '0},
    '{ACT_ENQ,  15'h5555,  16'd1,     32'd0,          5'd1,  1'b1,
      '{ST_FULL,      1'b0, 15'd0,     20'd0, 20'hFFFF0,  5'd16}},
    // duplicate wins over full
    '{ACT_ENQ,  15'd7,     16'd1,     32'd0,          5'd1,  1'b1,
      '{ST_DUPLICATE, 1'b0, 15'd0,     20'd0, 20'hFFFF0,  5'd16}},
    '{ACT_PICK, 15'd0,     16'd0,     32'd1048559,    5'd1,  1'b0, '0},
    '{ACT_DEQ,  15'd0,     16'd0,     32'd0,          5'd1,  1'b0, '0},
    '{ACT_DEQ,  15'd7,     16'd0,     32'd0,          5'd1,  1'b0, '0},
    '{ACT_CHG,  15'd32767, 16'd0,     32'hA5A5A5A5,   5'd1,  1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;

  lts_req_if req_ch();
  lts_rsp_if rsp_ch();

  lottery_task_scheduler #(.MAX_TASKS(MAX_TASKS)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // task table as the block should hold it
  id_t         tbl_id [MAX_TASKS];
  tix_t        tbl_tix[MAX_TASKS];
  int unsigned n_queued = 0;
  int unsigned tix_sum  = 0;

  result_t pending_results[$];
  int      mismatches   = 0;
  int      results_seen = 0;
  int      hold_left    = 0;
  bit      hold_done    = 1'b0;
  bit      steady       = 1'b0;   // no idling on either side

  function automatic result_t schedule_step(input item_t it);
    result_t     r;
    int unsigned slot;
    int unsigned draw;
    int unsigned run;
    r = '0;
    r.status = ST_OK;
    slot = n_queued;
    for (int unsigned i = 0; i < n_queued; i++)
      if (slot == n_queued && tbl_id[i] == it.id) slot = i;
    case (it.act)
      ACT_ENQ: begin
        if (slot < n_queued) r.status = ST_DUPLICATE;
        else if (n_queued >= MAX_TASKS) r.status = ST_FULL;
        else begin
          tbl_id[n_queued]  = it.id;
          tbl_tix[n_queued] = it.tix;
          n_queued++;
          tix_sum += it.tix;
        end
      end
      ACT_DEQ: begin
        if (slot >= n_queued) r.status = ST_ABSENT;
        else begin
          tix_sum -= tbl_tix[slot];
          for (int unsigned i = slot; i + 1 < n_queued; i++) begin
            tbl_id[i]  = tbl_id[i+1];
            tbl_tix[i] = tbl_tix[i+1];
          end
          n_queued--;
        end
      end
      ACT_PICK: begin
        if (tix_sum == 0) r.status = ST_EMPTY;
        else begin
          draw = it.rnd % tix_sum + 1;
          run  = 0;
          for (int unsigned i = 0; i < n_queued && !r.winner_valid; i++) begin
            run += tbl_tix[i];
            if (run >= draw) begin
              r.winner_valid = 1'b1;
              r.winner_id    = tbl_id[i];
              r.lucky        = total_out_t'(draw);
            end
          end
          if (!r.winner_valid) r.status = ST_EMPTY;
        end
      end
      default: begin
        if (slot >= n_queued) r.status = ST_ABSENT;
        else begin
          tix_sum = tix_sum - tbl_tix[slot] + it.tix;
          tbl_tix[slot] = it.tix;
        end
      end
    endcase
    r.total = total_out_t'(tix_sum);
    r.count = count_out_t'(n_queued);
    return r;
  endfunction

  // offer one item, wait for the transfer, then log what should come back
  task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
    result_t predicted;
    while (!steady && $urandom_range(99) < 29) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.action       <= it.act;
    req_ch.task_id      <= it.id;
    req_ch.tickets      <= it.tix;
    req_ch.random_value <= it.rnd;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = schedule_step(it);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  function automatic tix_t rand_tickets();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return tix_t'($urandom_range(15));
      default: return tix_t'($urandom_range(65535));
    endcase
  endfunction

  function automatic rnd_t rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return rnd_t'($urandom_range(1000));
      default: return $urandom;
    endcase
  endfunction

  // result side: check transfers, then decide ready for the next cycle
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status       = status_t'(rsp_ch.status);
      got.winner_valid = rsp_ch.winner_valid;
      got.winner_id    = rsp_ch.winner_id;
      got.lucky        = rsp_ch.lucky_number;
      got.total        = rsp_ch.ticket_total;
      got.count        = rsp_ch.entry_count;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result st=%0d wv=%0d id=%0d lucky=%0d",
                   $realtime, got.status, got.winner_valid, got.winner_id, got.lucky,
                   " total=%0d cnt=%0d", got.total, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %0d expected st=%0d wv=%0d id=%0d lucky=%0d",
                     $realtime, results_seen,
                     want.status, want.winner_valid, want.winner_id, want.lucky,
                     " total=%0d cnt=%0d, got st=%0d wv=%0d id=%0d lucky=%0d",
                     want.total, want.count,
                     got.status, got.winner_valid, got.winner_id, got.lucky,
                     " total=%0d cnt=%0d", got.total, got.count);
        end
      end
    end
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      // long back-pressure so the block fills and stalls its input
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= steady || $urandom_range(99) >= 29;
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    item_t   it;
    bit      filling;
    int      roll;
    bit      pick_queued;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.action       <= ACT_ENQ;
    req_ch.task_id      <= '0;
    req_ch.tickets      <= '0;
    req_ch.random_value <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[r]) begin
      for (int k = 0; k < DIRECTED[r].reps; k++) begin
        it.act = DIRECTED[r].act;
        it.id  = DIRECTED[r].id + id_t'(k);
        it.tix = DIRECTED[r].tix;
        it.rnd = DIRECTED[r].rnd;
        send_item(it, DIRECTED[r].typed, DIRECTED[r].res);
      end
    end

    filling = 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      steady = (i >= 400 && i < 550);
      if (n_queued == 0) filling = 1'b1;
      else if (n_queued == MAX_TASKS && $urandom_range(99) < 25) filling = 1'b0;
      else if ($urandom_range(99) < 3) filling = !filling;
      roll = $urandom_range(99);
      if (filling)
        it.act = roll < 50 ? ACT_ENQ : roll < 70 ? ACT_PICK : roll < 85 ? ACT_CHG : ACT_DEQ;
      else
        it.act = roll < 40 ? ACT_DEQ : roll < 65 ? ACT_PICK : roll < 80 ? ACT_CHG : ACT_ENQ;
      // mostly queued ids for dequeue/change, mostly fresh ids for enqueue
      pick_queued = (it.act == ACT_ENQ) ? ($urandom_range(99) < 15)
                                        : ($urandom_range(99) < 85);
      if (pick_queued && n_queued > 0) it.id = tbl_id[$urandom_range(n_queued - 1)];
      else it.id = id_t'($urandom_range(32767));
      it.tix = rand_tickets();
      it.rnd = rand_word();
      send_item(it, 1'b0, '0);
    end
    steady = 1'b0;
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
src/lts_pkg.sv
src/lts_req_if.sv
src/lts_rsp_if.sv
src/lts_divmod.sv
src/lottery_task_scheduler.sv
tb/sv/testbench.sv
